>>> sv/mfm_pkg.sv
// ----------------------------------------------------------------------------
// mfm_pkg: shared types and constants for the mantissa shift multiply unit
// Holds the sequencer state type and the fixed word constants.
// ----------------------------------------------------------------------------
package mfm_pkg;

    localparam int MANT_W  = 64;
    localparam int SHIFT_W = 8;
    localparam int PSH_W   = 10;
    localparam int EXP_W   = 11;
    localparam int PROD_W  = 2 * MANT_W;

    localparam logic [MANT_W-1:0] HALF_ONE = 64'h4000_0000_0000_0000;
    localparam logic [MANT_W-1:0] MAX_POS  = 64'h7fff_ffff_ffff_ffff;
    localparam logic [MANT_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;
    localparam logic [EXP_W-1:0]  WORD_EXP = 11'd64;

    // Index of the last partial product and of the last normalize step.
    localparam logic [1:0] MUL_LAST  = 2'd3;
    localparam logic [2:0] NORM_LAST = 3'd6;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_NORM  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_SIGN  = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

endpackage

>>> sv/mantissa_shift_multiply_64x64_unit.sv
// ----------------------------------------------------------------------------
// mantissa_shift_multiply_64x64_unit: block floating point 64x64 multiply
// Multiplies two mantissa/shift pairs, normalizes, rounds and saturates.
// ----------------------------------------------------------------------------
//
//  channel   ports                                       direction
//  s_        s_valid s_ready s_mant_a s_shift_a
//            s_mant_b s_shift_b                          in
//  m_        m_valid m_ready m_prod_mant m_prod_shift
//            m_saturated                                 out
//
// A nonzero word passes from acceptance to the output register through
// one load, four 32x32 partial products through the shared multiplier,
// seven binary normalize steps through one 128-bit shifter, then round,
// sign and finish. A zero operand goes straight from load to finish.
// s_ready is high only in the idle state; a result waits in the output
// register, and the finish state holds while the previous word is unread.
// aresetn is synchronous and active low and clears the control state.
module mantissa_shift_multiply_64x64_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [mfm_pkg::MANT_W-1:0]  s_mant_a,
    input  logic        [mfm_pkg::SHIFT_W-1:0] s_shift_a,
    input  logic signed [mfm_pkg::MANT_W-1:0]  s_mant_b,
    input  logic        [mfm_pkg::SHIFT_W-1:0] s_shift_b,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [mfm_pkg::MANT_W-1:0]  m_prod_mant,
    output logic        [mfm_pkg::PSH_W-1:0]   m_prod_shift,
    output logic                             m_saturated
);

    mfm_pkg::state_t state_reg, state_next;

    logic [mfm_pkg::MANT_W-1:0] a_reg, a_next;
    logic [mfm_pkg::MANT_W-1:0] b_reg, b_next;
    logic [mfm_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [mfm_pkg::EXP_W-1:0]  exp_reg, exp_next;
    logic                       neg_reg, neg_next;
    logic                       zero_reg, zero_next;
    logic [1:0]                 mcnt_reg, mcnt_next;
    logic [2:0]                 ncnt_reg, ncnt_next;
    logic [mfm_pkg::MANT_W-1:0] mag_reg, mag_next;

    logic                       m_valid_reg, m_valid_next;
    logic [mfm_pkg::MANT_W-1:0] out_mant_reg, out_mant_next;
    logic [mfm_pkg::PSH_W-1:0]  out_shift_reg, out_shift_next;
    logic                       out_sat_reg, out_sat_next;

    // Operand magnitudes and exponent adjustments on load.
    logic                       neg_a, neg_b;
    logic [mfm_pkg::MANT_W-1:0] mag_a, mag_b;
    logic                       adj_a, adj_b;

    // Shared multiplier and normalize shifter.
    logic [31:0]                mul_x, mul_y;
    logic [mfm_pkg::MANT_W-1:0] pp;
    logic [mfm_pkg::PROD_W-1:0] pp_shifted;
    logic [6:0]                 norm_k;
    logic                       norm_take;
    logic [mfm_pkg::MANT_W-1:0] hi_word;
    logic                       out_free;

    always_comb begin
        neg_a = s_mant_a[mfm_pkg::MANT_W-1];
        neg_b = s_mant_b[mfm_pkg::MANT_W-1];
        adj_a = (s_mant_a == mfm_pkg::TOP_BIT);
        adj_b = (s_mant_b == mfm_pkg::TOP_BIT);
        if (adj_a) begin
            mag_a = mfm_pkg::HALF_ONE;
        end else if (neg_a) begin
            mag_a = ~s_mant_a + 64'd1;
        end else begin
            mag_a = s_mant_a;
        end
        if (adj_b) begin
            mag_b = mfm_pkg::HALF_ONE;
        end else if (neg_b) begin
            mag_b = ~s_mant_b + 64'd1;
        end else begin
            mag_b = s_mant_b;
        end
    end

    assign mul_x      = mcnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign mul_y      = mcnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
    assign pp         = {32'd0, mul_x} * {32'd0, mul_y};
    assign pp_shifted = {64'd0, pp} << {({1'b0, mcnt_reg[0]} + {1'b0, mcnt_reg[1]}), 5'd0};

    always_comb begin
        unique case (ncnt_reg)
            3'd0:    norm_k = 7'd64;
            3'd1:    norm_k = 7'd32;
            3'd2:    norm_k = 7'd16;
            3'd3:    norm_k = 7'd8;
            3'd4:    norm_k = 7'd4;
            3'd5:    norm_k = 7'd2;
            default: norm_k = 7'd1;
        endcase
    end

    // Shift by k only when the top k+1 bits are clear, so the leading one
    // never passes bit 126 of the product.
    assign norm_take = ((prod_reg >> (7'd127 - norm_k)) == '0);
    assign hi_word   = prod_reg[mfm_pkg::PROD_W-1:mfm_pkg::MANT_W];
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        exp_next       = exp_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        mcnt_next      = mcnt_reg;
        ncnt_next      = ncnt_reg;
        mag_next       = mag_reg;
        m_valid_next   = m_valid_reg;
        out_mant_next  = out_mant_reg;
        out_shift_next = out_shift_reg;
        out_sat_next   = out_sat_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            mfm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    a_next    = mag_a;
                    b_next    = mag_b;
                    neg_next  = neg_a ^ neg_b;
                    zero_next = (s_mant_a == '0) || (s_mant_b == '0);
                    exp_next  = {3'd0, s_shift_a} + {3'd0, s_shift_b}
                              - {10'd0, adj_a} - {10'd0, adj_b};
                    prod_next = '0;
                    mcnt_next = '0;
                    ncnt_next = '0;
                    if ((s_mant_a == '0) || (s_mant_b == '0)) begin
                        state_next = mfm_pkg::ST_FIN;
                    end else begin
                        state_next = mfm_pkg::ST_MUL;
                    end
                end
            end
            mfm_pkg::ST_MUL: begin
                prod_next = prod_reg + pp_shifted;
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == mfm_pkg::MUL_LAST) begin
                    state_next = mfm_pkg::ST_NORM;
                end
            end
            mfm_pkg::ST_NORM: begin
                if (norm_take) begin
                    prod_next = prod_reg << norm_k;
                    exp_next  = exp_reg + {4'd0, norm_k};
                end
                ncnt_next = ncnt_reg + 3'd1;
                if (ncnt_reg == mfm_pkg::NORM_LAST) begin
                    state_next = mfm_pkg::ST_ROUND;
                end
            end
            mfm_pkg::ST_ROUND: begin
                if (prod_reg[mfm_pkg::MANT_W-1] && (hi_word != mfm_pkg::MAX_POS)) begin
                    mag_next = hi_word + 64'd1;
                end else begin
                    mag_next = hi_word;
                end
                state_next = mfm_pkg::ST_SIGN;
            end
            mfm_pkg::ST_SIGN: begin
                // The exponent is never negative enough to matter here: any
                // value below 64, including the signed ones, saturates.
                if (!exp_reg[mfm_pkg::EXP_W-1] && (exp_reg >= mfm_pkg::WORD_EXP)) begin
                    exp_next = exp_reg - mfm_pkg::WORD_EXP;
                    zero_next = 1'b0;
                end else begin
                    exp_next = '0;
                    mag_next = mfm_pkg::MAX_POS;
                    zero_next = 1'b1;
                end
                if (neg_reg) begin
                    if (!exp_reg[mfm_pkg::EXP_W-1] && (exp_reg >= mfm_pkg::WORD_EXP)) begin
                        mag_next = ~mag_reg + 64'd1;
                    end else begin
                        mag_next = ~mfm_pkg::MAX_POS + 64'd1;
                    end
                end
                state_next = mfm_pkg::ST_FIN;
            end
            mfm_pkg::ST_FIN: begin
                // On the zero path zero_reg marks a zero result; after the
                // sign step it carries the saturation flag instead.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (mcnt_reg == '0 && ncnt_reg == '0) begin
                        out_mant_next  = '0;
                        out_shift_next = '0;
                        out_sat_next   = 1'b0;
                    end else begin
                        out_mant_next  = mag_reg;
                        out_shift_next = exp_reg[mfm_pkg::PSH_W-1:0];
                        out_sat_next   = zero_reg;
                    end
                    state_next = mfm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mfm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mfm_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            mcnt_reg    <= '0;
            ncnt_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            mcnt_reg    <= mcnt_next;
            ncnt_reg    <= ncnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        prod_reg      <= prod_next;
        exp_reg       <= exp_next;
        neg_reg       <= neg_next;
        zero_reg      <= zero_next;
        mag_reg       <= mag_next;
        out_mant_reg  <= out_mant_next;
        out_shift_reg <= out_shift_next;
        out_sat_reg   <= out_sat_next;
    end

    assign s_ready      = (state_reg == mfm_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_prod_mant  = out_mant_reg;
    assign m_prod_shift = out_shift_reg;
    assign m_saturated  = out_sat_reg;

endmodule
